// ===== sv/ctrb_pkg.sv =====
// shared types and constants of the control transfer trb producer
package ctrb_pkg;

  localparam int RING_ENTRIES = 256;
  localparam int IDX_W        = 8;
  localparam logic [IDX_W-1:0] LINK_SLOT = IDX_W'(RING_ENTRIES - 1);

  localparam int SETUP_W  = 64;
  localparam int ADDR_W   = 64;
  localparam int PARAM_W  = 64;
  localparam int STATUS_W = 16;
  localparam int CTRL_W   = 32;
  localparam int BASE_W   = 48;
  localparam int LEN_LSB  = 48;

  localparam int S_TDATA_W = SETUP_W + ADDR_W;
  localparam int M_TDATA_W = IDX_W + PARAM_W + STATUS_W + CTRL_W;

  // trb types and control word fields
  localparam logic [5:0] TYPE_SETUP  = 6'd2;
  localparam logic [5:0] TYPE_DATA   = 6'd3;
  localparam logic [5:0] TYPE_STATUS = 6'd4;
  localparam logic [5:0] TYPE_LINK   = 6'd6;
  localparam int TYPE_LSB = 10;
  localparam int BIT_CYCLE = 0;
  localparam int BIT_TC    = 1;
  localparam int BIT_IOC   = 5;
  localparam int BIT_IDT   = 6;
  localparam int BIT_DIR   = 16;
  localparam int TRT_LSB   = 16;

  localparam logic [1:0] TRT_NO_DATA = 2'd0;
  localparam logic [1:0] TRT_OUT     = 2'd2;
  localparam logic [1:0] TRT_IN      = 2'd3;

  localparam logic [STATUS_W-1:0] SETUP_LEN = STATUS_W'(8);

  // apb
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 64;
  localparam logic REG_RING_BASE = 1'b0;

  // request queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [SETUP_W-1:0] setup;
    logic [ADDR_W-1:0]  addr;
    logic               data_in;
    logic               has_data;
    logic [1:0]         trt;
    logic               status_in;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_SETUP  = 4'b0001,
    ST_DATA   = 4'b0010,
    ST_STATUS = 4'b0100,
    ST_LINK   = 4'b1000
  } stage_t;

endpackage

// ===== sv/ctrb_front.sv =====
// request intake: classifies a control request into a queue command
module ctrb_front (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ctrb_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                           s_tuser,
  input  logic                           q_full,
  output logic                           q_push,
  output ctrb_pkg::cmd_t                 q_cmd
);
  import ctrb_pkg::*;

  logic [STATUS_W-1:0] len;
  logic                has_data;

  assign len      = s_tdata[LEN_LSB +: STATUS_W];
  assign has_data = (len != '0);

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_cmd.setup     = s_tdata[SETUP_W-1:0];
    q_cmd.addr      = s_tdata[SETUP_W +: ADDR_W];
    q_cmd.data_in   = s_tuser;
    q_cmd.has_data  = has_data;
    if (!has_data) begin
      q_cmd.trt = TRT_NO_DATA;
    end else if (s_tuser) begin
      q_cmd.trt = TRT_IN;
    end else begin
      q_cmd.trt = TRT_OUT;
    end
    // status stage runs opposite to the data stage, in when there is none
    q_cmd.status_in = !(has_data && s_tuser);
  end

endmodule

// ===== sv/ctrb_queue.sv =====
// short command queue between intake and trb sequencer
module ctrb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ctrb_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output ctrb_pkg::cmd_t head_cmd
);
  import ctrb_pkg::*;

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_cmd  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/ctrb_back.sv =====
// trb sequencer: emits setup, data, status and link trb writes
module ctrb_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [ctrb_pkg::BASE_W-1:0]    ring_base,
  input  logic                           q_not_empty,
  input  ctrb_pkg::cmd_t                 q_head,
  output logic                           q_pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ctrb_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tlast
);
  import ctrb_pkg::*;

  cmd_t             cmd;
  logic             busy;
  stage_t           stage;
  stage_t           ret_stage;
  logic             link_last;
  logic [IDX_W-1:0] enqueue_index;
  logic             cycle_state;

  logic [IDX_W-1:0]    out_index;
  logic [PARAM_W-1:0]  out_param;
  logic [STATUS_W-1:0] out_status;
  logic [CTRL_W-1:0]   out_ctrl;
  logic                out_last;

  logic                emit;
  logic                finish;
  logic [IDX_W-1:0]    next_index;
  logic                at_link;
  logic [IDX_W-1:0]    trb_index;
  logic [PARAM_W-1:0]  trb_param;
  logic [STATUS_W-1:0] trb_stat;
  logic [CTRL_W-1:0]   trb_ctrl;
  logic                trb_last;
  stage_t              follow;

  assign emit       = busy && (!m_tvalid || m_tready);
  assign next_index = enqueue_index + 1'b1;
  assign at_link    = (next_index == LINK_SLOT);

  always_comb begin
    trb_index  = enqueue_index;
    trb_param  = '0;
    trb_stat   = '0;
    trb_ctrl   = '0;
    trb_last   = 1'b0;
    follow     = ST_STATUS;
    trb_ctrl[BIT_CYCLE] = cycle_state;
    unique case (stage)
      ST_SETUP: begin
        trb_param  = cmd.setup;
        trb_stat   = SETUP_LEN;
        trb_ctrl[TYPE_LSB +: 6] = TYPE_SETUP;
        trb_ctrl[BIT_IDT]       = 1'b1;
        trb_ctrl[TRT_LSB +: 2]  = cmd.trt;
        follow = cmd.has_data ? ST_DATA : ST_STATUS;
      end
      ST_DATA: begin
        trb_param  = cmd.addr;
        trb_stat   = cmd.setup[LEN_LSB +: STATUS_W];
        trb_ctrl[TYPE_LSB +: 6] = TYPE_DATA;
        trb_ctrl[BIT_DIR]       = cmd.data_in;
        follow = ST_STATUS;
      end
      ST_STATUS: begin
        trb_ctrl[TYPE_LSB +: 6] = TYPE_STATUS;
        trb_ctrl[BIT_DIR]       = cmd.status_in;
        trb_ctrl[BIT_IOC]       = 1'b1;
        // a link write that follows takes over the last flag
        trb_last = !at_link;
        follow   = ST_SETUP;
      end
      ST_LINK: begin
        trb_index = LINK_SLOT;
        trb_param = PARAM_W'(ring_base);
        trb_ctrl[TYPE_LSB +: 6] = TYPE_LINK;
        trb_ctrl[BIT_TC]        = 1'b1;
        trb_last = link_last;
        follow   = ret_stage;
      end
      default: begin
        follow = ST_SETUP;
      end
    endcase
  end

  assign finish = emit && trb_last;
  assign q_pop  = q_not_empty && (!busy || finish);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      stage         <= ST_SETUP;
      ret_stage     <= ST_STATUS;
      link_last     <= 1'b0;
      enqueue_index <= '0;
      cycle_state   <= 1'b1;
    end else begin
      if (emit) begin
        if (stage == ST_LINK) begin
          enqueue_index <= '0;
          cycle_state   <= !cycle_state;
        end else begin
          enqueue_index <= next_index;
          if (at_link) begin
            ret_stage <= follow;
            link_last <= (stage == ST_STATUS);
          end
        end
      end
      if (q_pop) begin
        busy  <= 1'b1;
        stage <= ST_SETUP;
      end else begin
        if (finish) begin
          busy <= 1'b0;
        end
        if (emit) begin
          stage <= (stage != ST_LINK && at_link) ? ST_LINK : follow;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_index  <= trb_index;
      out_param  <= trb_param;
      out_status <= trb_stat;
      out_ctrl   <= trb_ctrl;
      out_last   <= trb_last;
    end
  end

  assign m_tdata = {out_ctrl, out_status, out_param, out_index};
  assign m_tlast = out_last;

endmodule

// ===== sv/control_transfer_trb_producer.sv =====
// top level of the control transfer trb producer
//
//  channel  | role                      | transaction
//  ---------+---------------------------+---------------------------------
//  s_*      | control request in        | setup packet, buffer, direction
//  m_*      | trb write out             | one trb to a ring slot
//  apb      | configuration             | ring base address (0x0)
//
// each request yields two to four trb writes, one per cycle from the single
// output register while it is not stalled; a new request is taken every cycle
// while the command queue has room, so the write count sets the sustained rate.
// reset clears the queue, sets the enqueue index to 0 and the cycle bit to 1.
// a stalled output holds its trb; the queue keeps taking requests until full.
module control_transfer_trb_producer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // setup_packet [63:0], data_address [127:64]
  input  logic [ctrb_pkg::S_TDATA_W-1:0]   s_tdata,
  // data_in [0]
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // trb_index [7:0], trb_parameter [71:8], trb_stat [87:72],
  // trb_control [119:88]
  output logic [ctrb_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic                             m_tlast,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ctrb_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ctrb_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ctrb_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import ctrb_pkg::*;

  logic              ring_base_sel;
  logic [BASE_W-1:0] ring_base_address;
  logic              q_full;
  logic              q_push;
  cmd_t              q_cmd;
  logic              q_pop;
  logic              q_not_empty;
  cmd_t              q_head;

  assign pready        = 1'b1;
  assign ring_base_sel = (paddr[APB_ADDR_W-1] == REG_RING_BASE);

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_base_address <= '0;
    end else if (psel && penable && pwrite && ring_base_sel) begin
      ring_base_address <= pwdata[BASE_W-1:0];
    end
  end

  assign prdata = ring_base_sel ? APB_DATA_W'(ring_base_address) : '0;

  ctrb_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  ctrb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (q_head)
  );

  ctrb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .ring_base   (ring_base_address),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule

// ===== test/tb_top.sv =====
// testbench of the control transfer trb producer: ring model, stream and apb drivers
`timescale 1ns / 100ps

module tb_top;
  import ctrb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [APB_ADDR_W-1:0] RING_BASE_PADDR = APB_ADDR_W'(8 * REG_RING_BASE);

  typedef struct {
    logic [IDX_W-1:0]    idx;
    logic [PARAM_W-1:0]  param;
    logic [STATUS_W-1:0] status;
    logic [CTRL_W-1:0]   ctrl;
    logic                last;
  } trb_t;

  // keeps its own copy of enqueue index, cycle bit and ring base
  class ring_writer_model;
    logic [BASE_W-1:0] ring_base;
    logic [IDX_W-1:0]  enq_idx;
    logic              cycle;
    trb_t              pending_trbs[$];
    int                mismatches;

    function new();
      ring_base = '0;
      enq_idx = '0;
      cycle = 1'b1;
      mismatches = 0;
    endfunction

    function void set_ring_base(logic [BASE_W-1:0] value);
      ring_base = value;
    endfunction

    function int pending();
      return pending_trbs.size();
    endfunction

    function void push_trb(ref trb_t batch[$], input logic [IDX_W-1:0] idx,
                           input logic [PARAM_W-1:0] param,
                           input logic [STATUS_W-1:0] status,
                           input logic [CTRL_W-1:0] ctrl);
      trb_t t;
      t.idx = idx;
      t.param = param;
      t.status = status;
      t.ctrl = ctrl;
      t.last = 1'b0;
      batch.push_back(t);
    endfunction

    // step past the slot just written; drop a link trb at the link slot
    function void advance(ref trb_t batch[$]);
      logic [CTRL_W-1:0] ctrl;
      enq_idx = enq_idx + 1'b1;
      if (enq_idx == LINK_SLOT) begin
        ctrl = '0;
        ctrl[TYPE_LSB +: 6] = TYPE_LINK;
        ctrl[BIT_TC] = 1'b1;
        ctrl[BIT_CYCLE] = cycle;
        push_trb(batch, LINK_SLOT, PARAM_W'(ring_base), '0, ctrl);
        enq_idx = '0;
        cycle = ~cycle;
      end
    endfunction

    function void note_request(logic [SETUP_W-1:0] setup, logic [ADDR_W-1:0] addr,
                               logic dir_in);
      trb_t              batch[$];
      logic [15:0]       len;
      logic [1:0]        trt;
      logic [CTRL_W-1:0] ctrl;
      len = setup[LEN_LSB +: 16];
      trt = (len == 0) ? TRT_NO_DATA : (dir_in ? TRT_IN : TRT_OUT);

      ctrl = '0;
      ctrl[TYPE_LSB +: 6] = TYPE_SETUP;
      ctrl[BIT_IDT] = 1'b1;
      ctrl[TRT_LSB +: 2] = trt;
      ctrl[BIT_CYCLE] = cycle;
      push_trb(batch, enq_idx, setup, SETUP_LEN, ctrl);
      advance(batch);

      if (len != 0) begin
        ctrl = '0;
        ctrl[TYPE_LSB +: 6] = TYPE_DATA;
        ctrl[BIT_DIR] = dir_in;
        ctrl[BIT_CYCLE] = cycle;
        push_trb(batch, enq_idx, addr, len, ctrl);
        advance(batch);
      end

      // status runs opposite to the data stage, in when there is none
      ctrl = '0;
      ctrl[TYPE_LSB +: 6] = TYPE_STATUS;
      ctrl[BIT_DIR] = !(len != 0 && dir_in);
      ctrl[BIT_IOC] = 1'b1;
      ctrl[BIT_CYCLE] = cycle;
      push_trb(batch, enq_idx, '0, '0, ctrl);
      advance(batch);

      batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) pending_trbs.push_back(batch[i]);
    endfunction

    task report_mismatch(string field, logic [PARAM_W-1:0] got, logic [PARAM_W-1:0] want);
      $display("mismatch on %s: got %h, want %h", field, got, want);
      mismatches++;
    endtask

    task check_trb(logic [M_TDATA_W-1:0] data, logic last);
      trb_t want;
      if (pending_trbs.size() == 0) begin
        report_mismatch("unexpected trb write", PARAM_W'(data[IDX_W-1:0]), '0);
      end else begin
        want = pending_trbs.pop_front();
        if (data[0 +: IDX_W] !== want.idx)
          report_mismatch("trb_index", PARAM_W'(data[0 +: IDX_W]), PARAM_W'(want.idx));
        if (data[IDX_W +: PARAM_W] !== want.param)
          report_mismatch("trb_parameter", data[IDX_W +: PARAM_W], want.param);
        if (data[IDX_W+PARAM_W +: STATUS_W] !== want.status)
          report_mismatch("trb_stat", PARAM_W'(data[IDX_W+PARAM_W +: STATUS_W]),
                          PARAM_W'(want.status));
        if (data[IDX_W+PARAM_W+STATUS_W +: CTRL_W] !== want.ctrl)
          report_mismatch("trb_control", PARAM_W'(data[IDX_W+PARAM_W+STATUS_W +: CTRL_W]),
                          PARAM_W'(want.ctrl));
        if (last !== want.last)
          report_mismatch("last_write", PARAM_W'(last), PARAM_W'(want.last));
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // setup_packet [63:0], data_address [127:64]
  logic [S_TDATA_W-1:0]   s_tdata = '0;
  // data_in [0]
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // trb_index [7:0], trb_parameter [71:8], trb_stat [87:72], trb_control [119:88]
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   m_tlast;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  logic src_idle = 1'b0;
  logic sink_idle = 1'b0;
  logic hold_req = 1'b0;
  int   cycles = 0;

  ring_writer_model model = new();

  control_transfer_trb_producer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // trb receiver: checks each transaction, then picks the next ready level
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) model.check_trb(m_tdata, m_tlast);
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req <= 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (sink_idle && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 17);
      end
    end
  end

  task automatic send_request(input logic [SETUP_W-1:0] setup, input logic [ADDR_W-1:0] addr,
                              input logic dir_in);
    int gap;
    gap = (src_idle && $urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {addr, setup};
    s_tuser <= dir_in;
    do @(posedge clk); while (!s_tready);
    model.note_request(setup, addr, dir_in);
  endtask

  task automatic send_random();
    logic [SETUP_W-1:0] setup;
    logic [ADDR_W-1:0]  addr;
    int                 pick;
    pick = $urandom_range(0, 9);
    setup = {$urandom, $urandom};
    if (pick < 3) setup[LEN_LSB +: 16] = '0;
    else if (pick == 3) setup[LEN_LSB +: 16] = 16'hFFFF;
    else if (pick < 6) setup[LEN_LSB +: 16] = 16'($urandom_range(1, 64));
    addr = {$urandom, $urandom};
    if ($urandom_range(0, 15) == 0) addr = '0;
    send_request(setup, addr, 1'($urandom_range(0, 1)));
  endtask

  task automatic write_ring_base(input logic [APB_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= RING_BASE_PADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    model.set_ring_base(value[BASE_W-1:0]);
  endtask

  // wait out every expected trb, then let the bench settle before touching config
  task automatic drain();
    s_tvalid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, no idling
    write_ring_base('0);
    send_request('0, '0, 1'b0);
    send_request('0, '0, 1'b1);
    send_request('1, '1, 1'b1);
    send_request('1, '1, 1'b0);
    send_request({16'd1, 48'h0000_0000_0680}, '0, 1'b0);
    send_request({16'd1, 48'h0000_0000_0680}, '0, 1'b1);
    send_request({16'h8000, 48'hAAAA_5555_AAAA}, 64'h5555_AAAA_5555_AAAA, 1'b1);
    send_request({16'h0000, 48'h5555_AAAA_5555}, 64'hAAAA_5555_AAAA_5555, 1'b1);
    send_request({16'h0000, 48'hFFFF_FFFF_FFFF}, '1, 1'b0);
    send_request({16'hFFFF, 48'h0}, '0, 1'b0);
    send_request({16'h0012, 48'h0100_0000_0680}, 64'h0000_0001_0000_0000, 1'b1);
    send_request({16'h0040, 48'h0000_0001_0900}, 64'h8000_0000_0000_0000, 1'b0);
    drain();

    // base all ones, upper pwdata bits set too; idling and a long output hold
    write_ring_base('1);
    src_idle <= 1'b1;
    sink_idle <= 1'b1;
    for (int i = 0; i < 120; i++) begin
      if (i == 40) hold_req <= 1'b1;
      send_random();
    end
    drain();

    write_ring_base({$urandom, $urandom});
    for (int i = 0; i < 120; i++) send_random();
    // idling stops here so no stall burst reaches into the last part
    src_idle <= 1'b0;
    sink_idle <= 1'b0;
    drain();

    // last part runs with no idling
    write_ring_base(64'({$urandom_range(0, 65535), $urandom}));
    for (int i = 0; i < 130; i++) send_random();
    drain();

    if (model.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
